// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the top-level RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RGBAG_ASSERT_IMP(lbl, clk, rst_n, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("rgbag same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RGBAG_ASSERT_NXT(lbl, clk, rst_n, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("rgbag next-cycle check failed");

`endif

// ===== rtl/rgbag_pkg.sv =====
`default_nettype none

package rgbag_pkg;

  localparam int PIX_W  = 8;
  localparam int LUMA_W = 20;
  localparam int GAIN_W = 9;
  localparam int OFF_W  = 7;
  localparam int CODE_W = 7;

  // Luma weights, Q.12
  localparam logic [11:0] WEIGHT_R = 12'd1205;
  localparam logic [11:0] WEIGHT_G = 12'd2304;
  localparam logic [11:0] WEIGHT_B = 12'd587;

  localparam logic [LUMA_W-1:0] LUMA_MAX = 20'd1044480;  // 255 in Q.12
  localparam logic [LUMA_W-1:0] LUMA_MID = 20'd520192;   // 127 in Q.12

  localparam logic [GAIN_W-1:0] GAIN_FULL  = 9'd256;
  localparam logic [10:0]       SCALE_NUM  = 11'd1126;    // 0.275 in Q.12
  localparam logic [CODE_W-1:0] GLYPH_BASE = 7'd32;

  // Load enables for a module that holds two register stages
  typedef struct packed {
    logic load_a;
    logic load_b;
  } stage_en_t;

  // Nearest glyph index for brightness level 185 + off (first index on ties)
  function automatic logic [CODE_W-1:0] glyph_index(input logic [OFF_W-1:0] off);
    logic [CODE_W-1:0] idx;
    case (off)
      7'd0, 7'd1:                        idx = 7'd46;
      7'd2, 7'd3, 7'd4, 7'd5:            idx = 7'd32;
      7'd6, 7'd7, 7'd8:                  idx = 7'd16;
      7'd9:                              idx = 7'd24;
      7'd10:                             idx = 7'd34;
      7'd11:                             idx = 7'd49;
      7'd12:                             idx = 7'd3;
      7'd13:                             idx = 7'd50;
      7'd14:                             idx = 7'd6;
      7'd15:                             idx = 7'd25;
      7'd16:                             idx = 7'd47;
      7'd17:                             idx = 7'd40;
      7'd18:                             idx = 7'd33;
      7'd19:                             idx = 7'd4;
      7'd20:                             idx = 7'd5;
      7'd21:                             idx = 7'd53;
      7'd22, 7'd23:                      idx = 7'd18;
      7'd24:                             idx = 7'd65;
      7'd25:                             idx = 7'd20;
      7'd26:                             idx = 7'd69;
      7'd27:                             idx = 7'd87;
      7'd28:                             idx = 7'd79;
      7'd29:                             idx = 7'd35;
      7'd30:                             idx = 7'd38;
      7'd31:                             idx = 7'd36;
      7'd32:                             idx = 7'd17;
      7'd33:                             idx = 7'd52;
      7'd34:                             idx = 7'd10;
      7'd35:                             idx = 7'd70;
      7'd36:                             idx = 7'd74;
      7'd37:                             idx = 7'd67;
      7'd38:                             idx = 7'd44;
      7'd39:                             idx = 7'd31;
      7'd40:                             idx = 7'd28;
      7'd41:                             idx = 7'd29;
      7'd42:                             idx = 7'd8;
      7'd43, 7'd44:                      idx = 7'd15;
      7'd45, 7'd46:                      idx = 7'd62;
      7'd47:                             idx = 7'd2;
      7'd48:                             idx = 7'd94;
      7'd49, 7'd50:                      idx = 7'd1;
      7'd51:                             idx = 7'd63;
      7'd52, 7'd53:                      idx = 7'd26;
      7'd54:                             idx = 7'd13;
      7'd55, 7'd56:                      idx = 7'd12;
      7'd57, 7'd58:                      idx = 7'd7;
      7'd59, 7'd60:                      idx = 7'd14;
      7'd61, 7'd62, 7'd63, 7'd64, 7'd65: idx = 7'd64;
      default:                           idx = 7'd0;   // levels 251 and up
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rgb_pixel_to_ascii_glyph.sv =====
// Channel  Dir  Handshake          Payload
// in       in   in_valid/in_stall  in_red, in_green, in_blue (8 b each)
// out      out  out_valid/out_stall out_glyph_code (7 b, ASCII 32..126)
// cfg      in   cfg_valid/cfg_ready cfg_contrast_gain (9 b, Q1.8)
//
// Five register stages: luma, contrast product, stretch, scale, glyph lookup.
// One pixel per cycle sustained while out_stall is low; out_valid is the stage 5 valid bit.
// Reset (rst_n low, synchronous) empties the pipe and clears the gain to 0.
// out_stall holds each full stage with no empty stage after it; empty stages still fill, so
// in_stall rises only when all five stages hold a request.
// cfg_ready is always high; the gain must be written only while the pipe is empty (not enforced).
`default_nettype none

`include "assert_macros.svh"

module rgb_pixel_to_ascii_glyph (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [rgbag_pkg::PIX_W-1:0]      in_red,
  input  wire logic [rgbag_pkg::PIX_W-1:0]      in_green,
  input  wire logic [rgbag_pkg::PIX_W-1:0]      in_blue,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [rgbag_pkg::CODE_W-1:0]     out_glyph_code,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [rgbag_pkg::GAIN_W-1:0]     cfg_contrast_gain
);

  logic [4:0]                   valid_r;
  logic [4:0]                   valid_nxt;
  logic [4:0]                   adv;
  logic [rgbag_pkg::GAIN_W-1:0] gain_r;
  logic [rgbag_pkg::LUMA_W-1:0] luma;
  logic [rgbag_pkg::LUMA_W-1:0] stretched;
  rgbag_pkg::stage_en_t         contrast_en;
  rgbag_pkg::stage_en_t         glyph_en;

  // contrast register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      gain_r <= cfg_contrast_gain;
    end
  end

  // a stage moves when it is empty or the stage after it moves
  assign adv[4] = !valid_r[4] || !out_stall;
  assign adv[3] = !valid_r[3] || adv[4];
  assign adv[2] = !valid_r[2] || adv[3];
  assign adv[1] = !valid_r[1] || adv[2];
  assign adv[0] = !valid_r[0] || adv[1];

  assign in_stall = !adv[0];

  // valid bits travel with the data
  always_comb begin
    valid_nxt[0] = adv[0] ? in_valid   : valid_r[0];
    valid_nxt[1] = adv[1] ? valid_r[0] : valid_r[1];
    valid_nxt[2] = adv[2] ? valid_r[1] : valid_r[2];
    valid_nxt[3] = adv[3] ? valid_r[2] : valid_r[3];
    valid_nxt[4] = adv[4] ? valid_r[3] : valid_r[4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign out_valid = valid_r[4];

  // datapath
  assign contrast_en = '{load_a: adv[1], load_b: adv[2]};
  assign glyph_en    = '{load_a: adv[3], load_b: adv[4]};

  rgbag_luma u_luma (
    .clk    (clk),
    .en     (adv[0]),
    .red    (in_red),
    .green  (in_green),
    .blue   (in_blue),
    .luma_r (luma)
  );

  rgbag_contrast u_contrast (
    .clk         (clk),
    .en          (contrast_en),
    .luma        (luma),
    .gain        (gain_r),
    .stretched_r (stretched)
  );

  rgbag_glyph u_glyph (
    .clk       (clk),
    .en        (glyph_en),
    .stretched (stretched),
    .code_r    (out_glyph_code)
  );

  // checks
  `RGBAG_ASSERT_IMP(a_stall_only_when_full, clk, rst_n, in_stall, valid_r == 5'b11111)
  `RGBAG_ASSERT_NXT(a_stage4_reaches_out, clk, rst_n, valid_r[3] && adv[4], out_valid)
  `RGBAG_ASSERT_IMP(a_code_printable, clk, rst_n, out_valid,
                    (out_glyph_code >= 7'd32) && (out_glyph_code <= 7'd126))

endmodule

`default_nettype wire

// ===== rtl/rgbag_luma.sv =====
`default_nettype none

// Stage 1: weighted luma in Q.12
module rgbag_luma (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic [rgbag_pkg::PIX_W-1:0]      red,
  input  wire logic [rgbag_pkg::PIX_W-1:0]      green,
  input  wire logic [rgbag_pkg::PIX_W-1:0]      blue,
  output logic      [rgbag_pkg::LUMA_W-1:0]     luma_r
);

  logic [rgbag_pkg::LUMA_W-1:0] pr;
  logic [rgbag_pkg::LUMA_W-1:0] pg;
  logic [rgbag_pkg::LUMA_W-1:0] pb;
  logic [rgbag_pkg::LUMA_W-1:0] luma_nxt;

  // constant-coefficient products; the sum is at most 255 * 4096
  assign pr       = {12'b0, red}   * {8'b0, rgbag_pkg::WEIGHT_R};
  assign pg       = {12'b0, green} * {8'b0, rgbag_pkg::WEIGHT_G};
  assign pb       = {12'b0, blue}  * {8'b0, rgbag_pkg::WEIGHT_B};
  assign luma_nxt = pr + pg + pb;

  always_ff @(posedge clk) begin
    if (en) begin
      luma_r <= luma_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rgbag_contrast.sv =====
`default_nettype none

// Stages 2 and 3: contrast stretch of the luma
module rgbag_contrast (
  input  wire logic                             clk,
  input  wire rgbag_pkg::stage_en_t             en,
  input  wire logic [rgbag_pkg::LUMA_W-1:0]     luma,
  input  wire logic [rgbag_pkg::GAIN_W-1:0]     gain,
  output logic      [rgbag_pkg::LUMA_W-1:0]     stretched_r
);

  logic [rgbag_pkg::GAIN_W-1:0] gain_sat;
  logic                         bright;
  logic [rgbag_pkg::LUMA_W-1:0] diff;
  logic [28:0]                  prod;

  logic                         bright_r;
  logic [rgbag_pkg::LUMA_W-1:0] luma_r;
  logic [rgbag_pkg::LUMA_W-1:0] adj_r;
  logic [rgbag_pkg::LUMA_W-1:0] stretched_nxt;

  // gain above full counts as full
  assign gain_sat = (gain > rgbag_pkg::GAIN_FULL) ? rgbag_pkg::GAIN_FULL : gain;
  assign bright   = luma > rgbag_pkg::LUMA_MID;
  assign diff     = bright ? (rgbag_pkg::LUMA_MAX - luma) : luma;
  assign prod     = {9'b0, diff} * {20'b0, gain_sat};

  // stage 2: adjustment = floor(diff * gain / 256), never above diff
  always_ff @(posedge clk) begin
    if (en.load_a) begin
      bright_r <= bright;
      luma_r   <= luma;
      adj_r    <= prod[27:8];
    end
  end

  // stage 3: push toward white or black
  assign stretched_nxt = bright_r ? (luma_r + adj_r) : (luma_r - adj_r);

  always_ff @(posedge clk) begin
    if (en.load_b) begin
      stretched_r <= stretched_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rgbag_glyph.sv =====
`default_nettype none

// Stages 4 and 5: scale to a level offset, then glyph table lookup
module rgbag_glyph (
  input  wire logic                             clk,
  input  wire rgbag_pkg::stage_en_t             en,
  input  wire logic [rgbag_pkg::LUMA_W-1:0]     stretched,
  output logic      [rgbag_pkg::CODE_W-1:0]     code_r
);

  logic [30:0]                  scaled;
  logic [rgbag_pkg::OFF_W-1:0]  off_r;
  logic [rgbag_pkg::CODE_W-1:0] code_nxt;

  // offset = floor(v * 1126 / 2^24), at most 70
  assign scaled = {11'b0, stretched} * {20'b0, rgbag_pkg::SCALE_NUM};

  always_ff @(posedge clk) begin
    if (en.load_a) begin
      off_r <= scaled[30:24];
    end
  end

  assign code_nxt = rgbag_pkg::glyph_index(off_r) + rgbag_pkg::GLYPH_BASE;

  always_ff @(posedge clk) begin
    if (en.load_b) begin
      code_r <= code_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  // Luma and stretch constants (Q.12), glyph range, pipe depth and run limit
  localparam int unsigned LUMA_MID_Q12 = 127 * 4096;
  localparam int unsigned LUMA_MAX_Q12 = 255 * 4096;
  localparam int unsigned GAIN_SAT     = 256;
  localparam int unsigned LEVEL_BASE   = 185;
  localparam int unsigned SCALE_Q12    = 1126;
  localparam int unsigned ASCII_FIRST  = 32;
  localparam int unsigned GLYPH_TOTAL  = 95;
  localparam int unsigned PIPE_DEPTH   = 5;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // Ink brightness per glyph, entry 0 in the top byte
  localparam logic [95*8-1:0] INK_LEVELS = {
    8'd255, 8'd235, 8'd232, 8'd197, 8'd204, 8'd205, 8'd199,
    8'd243, 8'd227, 8'd227, 8'd219, 8'd227, 8'd240, 8'd239,
    8'd244, 8'd228, 8'd193, 8'd217, 8'd208, 8'd208, 8'd210,
    8'd205, 8'd199, 8'd219, 8'd194, 8'd200, 8'd238, 8'd232,
    8'd225, 8'd226, 8'd226, 8'd224, 8'd189, 8'd203, 8'd195,
    8'd214, 8'd216, 8'd200, 8'd215, 8'd203, 8'd202, 8'd214,
    8'd216, 8'd203, 8'd223, 8'd189, 8'd185, 8'd201, 8'd204,
    8'd196, 8'd198, 8'd204, 8'd218, 8'd206, 8'd210, 8'd194,
    8'd205, 8'd218, 8'd204, 8'd217, 8'd228, 8'd217, 8'd231,
    8'd236, 8'd247, 8'd209, 8'd204, 8'd222, 8'd204, 8'd211,
    8'd220, 8'd199, 8'd211, 8'd223, 8'd221, 8'd210, 8'd225,
    8'd210, 8'd218, 8'd213, 8'd204, 8'd204, 8'd231, 8'd219,
    8'd222, 8'd217, 8'd222, 8'd212, 8'd219, 8'd214, 8'd219,
    8'd218, 8'd227, 8'd218, 8'd233
  };

  typedef struct {
    logic [rgbag_pkg::PIX_W-1:0]  red;
    logic [rgbag_pkg::PIX_W-1:0]  green;
    logic [rgbag_pkg::PIX_W-1:0]  blue;
    logic [rgbag_pkg::GAIN_W-1:0] gain;
    logic [rgbag_pkg::CODE_W-1:0] code;
  } glyph_req_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [rgbag_pkg::PIX_W-1:0]   in_red = '0;
  logic [rgbag_pkg::PIX_W-1:0]   in_green = '0;
  logic [rgbag_pkg::PIX_W-1:0]   in_blue = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [rgbag_pkg::CODE_W-1:0]  out_glyph_code;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [rgbag_pkg::GAIN_W-1:0]  cfg_contrast_gain = '0;

  // Testbench copy of the gain register
  logic [rgbag_pkg::GAIN_W-1:0]  gain_shadow = '0;

  glyph_req_t  pending_glyphs[$];
  glyph_req_t  head_req;
  int unsigned cycle_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned glyphs_seen = 0;
  int unsigned gain_writes = 0;
  int unsigned mismatches = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  bit          rx_bursts = 1'b1;

  rgb_pixel_to_ascii_glyph uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_glyph_code    (out_glyph_code),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_contrast_gain (cfg_contrast_gain)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Expected glyph for one pixel at a given gain
  function automatic logic [rgbag_pkg::CODE_W-1:0] ascii_for_pixel(
      input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
      input logic [8:0] gain);
    logic [63:0] luma;
    logic [63:0] gsat;
    logic [63:0] stretched;
    logic [63:0] level;
    logic [63:0] ink;
    logic [63:0] ink_gap;
    logic [63:0] best_dist;
    int unsigned best;
    luma = 64'd1205 * r + 64'd2304 * g + 64'd587 * b;
    gsat = (gain > GAIN_SAT) ? 64'(GAIN_SAT) : 64'(gain);
    if (luma > LUMA_MID_Q12) begin
      stretched = luma + (((LUMA_MAX_Q12 - luma) * gsat) >> 8);
    end else begin
      stretched = luma - ((luma * gsat) >> 8);
    end
    level = LEVEL_BASE + ((stretched * SCALE_Q12) >> 24);
    best = 0;
    best_dist = 64'hFFFF_FFFF;
    // first entry wins on equal distance
    for (int i = 0; i < GLYPH_TOTAL; i++) begin
      ink = 64'(INK_LEVELS[(GLYPH_TOTAL - 1 - i) * 8 +: 8]);
      ink_gap = (level > ink) ? level - ink : ink - level;
      if (ink_gap < best_dist) begin
        best_dist = ink_gap;
        best = i;
      end
    end
    return 7'(best + ASCII_FIRST);
  endfunction

  // Receiver: random stall bursts, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_request != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_request - 1;
      hold_request = 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (rx_bursts && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result check; a request seen here is taken at the next rising edge
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      glyphs_seen++;
      if (pending_glyphs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected glyph %0d with nothing pending", out_glyph_code);
      end else begin
        head_req = pending_glyphs.pop_front();
        if (out_glyph_code !== head_req.code) begin
          mismatches++;
          if (mismatches <= 10)
            $display("glyph mismatch: pixel (%0d,%0d,%0d) gain %0d exp %0d got %0d",
                     head_req.red, head_req.green, head_req.blue, head_req.gain,
                     head_req.code, out_glyph_code);
        end
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("FAIL");
    $finish;
  end

  // Offer one pixel and hold it until taken; valid stays high on return
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
    glyph_req_t req;
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    req.red   = r;
    req.green = g;
    req.blue  = b;
    req.gain  = gain_shadow;
    req.code  = ascii_for_pixel(r, g, b, gain_shadow);
    pending_glyphs.push_back(req);
    pixels_sent++;
    @(posedge clk);
  endtask

  task automatic sender_gap(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop offering and wait for every pending glyph
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_glyphs.size() != 0) @(posedge clk);
  endtask

  // Gain is written only with the pipe empty
  task automatic set_gain(input logic [8:0] gain);
    wait_drained();
    repeat (PIPE_DEPTH + 3) @(posedge clk);
    cfg_valid         <= 1'b1;
    cfg_contrast_gain <= gain;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid   <= 1'b0;
    gain_shadow = gain;
    gain_writes++;
  endtask

  // Mix of uniform, near-mid gray and saturated pixels
  task automatic send_random_pixel();
    logic [7:0] r, g, b;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    r = 8'($urandom_range(0, 255));
    g = 8'($urandom_range(0, 255));
    b = 8'($urandom_range(0, 255));
    if (pick < 2) begin
      r = 8'($urandom_range(118, 137));
      g = r;
      b = r;
    end else if (pick < 4) begin
      r = ($urandom_range(0, 2) == 0) ? r : ($urandom_range(0, 1) ? 8'hFF : 8'h00);
      g = ($urandom_range(0, 2) == 0) ? g : ($urandom_range(0, 1) ? 8'hFF : 8'h00);
      b = ($urandom_range(0, 2) == 0) ? b : ($urandom_range(0, 1) ? 8'hFF : 8'h00);
    end
    send_pixel(r, g, b);
  endtask

  // Field extremes and the bright/dark boundary at several gains
  task automatic test_directed();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd127, 8'd127, 8'd127);   // luma exactly at mid: dark side
    send_pixel(8'd128, 8'd128, 8'd128);   // first gray on the bright side
    send_pixel(8'hAA, 8'h55, 8'hAA);
    send_pixel(8'h55, 8'hAA, 8'h55);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd1, 8'd1, 8'd1);
    set_gain(9'd256);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd127, 8'd127, 8'd127);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd200, 8'd100, 8'd50);
    // gain above full saturates
    set_gain(9'd511);
    send_pixel(8'd127, 8'd127, 8'd127);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd60, 8'd180, 8'd90);
  endtask

  // Random pixels across gain settings, both sides idling in bursts
  task automatic test_gain_sweep();
    logic [8:0] gains[9];
    gains = '{9'd0, 9'd511, 9'd256, 9'd1, 9'd128, 9'd257, 9'd64,
              9'($urandom_range(0, 511)), 9'($urandom_range(0, 256))};
    foreach (gains[k]) begin
      set_gain(gains[k]);
      repeat (70) begin
        send_random_pixel();
        if ($urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 13));
      end
    end
  endtask

  // Receiver holds off long enough for the pipe to fill and stall the input
  task automatic test_backpressure();
    set_gain(9'($urandom_range(0, 300)));
    hold_request = 80;
    repeat (30) send_random_pixel();
    wait_drained();
    repeat (10) send_random_pixel();
  endtask

  // Closing stretch at full rate with no idling on either side
  task automatic test_full_rate();
    rx_bursts = 1'b0;
    set_gain(9'($urandom_range(0, 511)));
    repeat (150) send_random_pixel();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_gain_sweep();
    test_backpressure();
    test_full_rate();
    wait_drained();
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    $display("sent %0d pixels over %0d gain writes, %0d glyphs checked, %0d mismatches",
             pixels_sent, gain_writes, glyphs_seen, mismatches);
    $display("covered field extremes, mid-gray boundary, gain saturation and backpressure");
    if (mismatches == 0 && pending_glyphs.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rgbag_pkg.sv
rtl/rgbag_luma.sv
rtl/rgbag_contrast.sv
rtl/rgbag_glyph.sv
rtl/rgb_pixel_to_ascii_glyph.sv
tb/sv/testbench.sv
